// ===== hw/rtl/chinese_wall_access_check_core_assert.svh =====
// ----------------------------------------------------------------------------
// chinese wall access check: assertion macros
// clocked on clk, disabled while arst_n is low; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef CHINESE_WALL_ACCESS_CHECK_CORE_ASSERT_SVH
`define CHINESE_WALL_ACCESS_CHECK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// plain property check
`define CWAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// same-cycle implication
`define CWAC_ASSERT_IMP(lbl, ante, cons, msg) \
	`CWAC_ASSERT(lbl, (ante) |-> (cons), msg)
// next-cycle implication
`define CWAC_ASSERT_NXT(lbl, ante, cons, msg) \
	`CWAC_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define CWAC_ASSERT(lbl, prop, msg)
`define CWAC_ASSERT_IMP(lbl, ante, cons, msg)
`define CWAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/cwac_pkg.sv =====
// ----------------------------------------------------------------------------
// cwac_pkg
// types and fixed sizes of the chinese wall access checker
// ----------------------------------------------------------------------------
package cwac_pkg;

	// table sizes
	localparam int SUBJECT_COUNT = 8;
	localparam int OBJECT_COUNT  = 16;
	localparam int FIRM_COUNT    = 8;

	localparam int SUBJ_W  = 3;
	localparam int OBJ_W   = 4;
	localparam int FIRM_W  = 3;
	localparam int NSUBJ_W = 4;
	localparam int NOBJ_W  = 5;

	// request kinds
	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	// result codes
	typedef enum logic [1:0] {
		STATUS_REFUSED = 2'd0,
		STATUS_GRANTED = 2'd1,
		STATUS_INVALID = 2'd2,
		STATUS_CLEARED = 2'd3
	} status_t;

	// register map index (byte address / 8)
	typedef enum logic [1:0] {
		REG_OWNER    = 2'd0,
		REG_CONFLICT = 2'd1,
		REG_SUBJECTS = 2'd2,
		REG_OBJECTS  = 2'd3
	} reg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

// ===== hw/rtl/chinese_wall_access_check_core.sv =====
// ----------------------------------------------------------------------------
// chinese_wall_access_check_core
// brewer-nash access checker with per-subject history rows
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive kind, subject and object with start high; the
//   word is taken at the clock edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with status valid; the
//   receiver cannot stall, so it must sample status whenever done is high.
//   Config: APB-style, 64-bit data, registers at byte addresses 0, 8, 16, 24
//   (owner table, conflict matrix, subjects in use, objects in use); write
//   only while busy is low. pready is tied high.
// Sequencing:
//   clear, invalid index and unknown kind: done in the cycle after accept;
//   the next word is taken once the sequencer is back in idle after done.
//   read/write: one checker step per object in use, in index order over the
//   history row; a grant shows done after the last step, and a refusal ends
//   at the first conflicting entry. No new word is taken until the result
//   is done. The scan loop over the history row sets the rate.
// Reset:
//   history is cleared, owner table and conflict matrix zero, subjects in
//   use 8, objects in use 16; the sequencer returns to idle.
// ----------------------------------------------------------------------------
`include "chinese_wall_access_check_core_assert.svh"

module chinese_wall_access_check_core
	import cwac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [2:0]  subject,
	input  logic [3:0]  object,
	// result
	output logic        done,
	output logic [1:0]  status,
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	// config registers
	logic [47:0]        owner_q;
	logic [63:0]        conflict_q;
	logic [NSUBJ_W-1:0] subjects_q;
	logic [NOBJ_W-1:0]  objects_q;

	// history rows
	logic [OBJECT_COUNT-1:0] hist_q [SUBJECT_COUNT];

	// per-request working registers
	state_t                  state_q, state_d;
	logic [SUBJ_W-1:0]       subj_q;
	logic [OBJ_W-1:0]        obj_q;
	logic [FIRM_W-1:0]       firm_q;
	logic [OBJECT_COUNT-1:0] row_q;
	logic [OBJ_W-1:0]        idx_q;
	status_t                 status_q;

	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	logic [NSUBJ_W-1:0] n_subj;
	logic [NOBJ_W-1:0]  n_obj;
	logic               req_bad;
	logic               accept;
	logic               hit;
	logic               last;
	logic [FIRM_W-1:0]  firm_cur;
	logic [FIRM_W-1:0]  firm_req;
	logic               hist_clear;
	logic               hist_set;

	// config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q    <= '0;
			conflict_q <= '0;
			subjects_q <= NSUBJ_W'(SUBJECT_COUNT);
			objects_q  <= NOBJ_W'(OBJECT_COUNT);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_OWNER:    owner_q    <= pwdata[47:0];
				REG_CONFLICT: conflict_q <= pwdata;
				REG_SUBJECTS: subjects_q <= pwdata[NSUBJ_W-1:0];
				REG_OBJECTS:  objects_q  <= pwdata[NOBJ_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_OWNER:    prdata = {16'd0, owner_q};
			REG_CONFLICT: prdata = conflict_q;
			REG_SUBJECTS: prdata = {{(64-NSUBJ_W){1'b0}}, subjects_q};
			REG_OBJECTS:  prdata = {{(64-NOBJ_W){1'b0}}, objects_q};
			default:      prdata = '0;
		endcase
	end

	// counts in use, capped at table sizes
	assign n_subj = (subjects_q > NSUBJ_W'(SUBJECT_COUNT)) ? NSUBJ_W'(SUBJECT_COUNT)
	                                                       : subjects_q;
	assign n_obj  = (objects_q > NOBJ_W'(OBJECT_COUNT)) ? NOBJ_W'(OBJECT_COUNT)
	                                                    : objects_q;
	assign req_bad = ({1'b0, subject} >= n_subj) || ({1'b0, object} >= n_obj);

	// owner lookups: requested object and current scan entry
	assign firm_req = owner_q[object * FIRM_W +: FIRM_W];
	assign firm_cur = owner_q[idx_q * FIRM_W +: FIRM_W];

	// shared check unit: one history entry per cycle
	// every 3-bit firm is below FIRM_COUNT, so no range gate is needed
	assign hit  = row_q[idx_q] && (firm_cur != firm_q) && conflict_q[{firm_q, firm_cur}];
	assign last = ({1'b0, idx_q} == (n_obj - NOBJ_W'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind == KIND_READ || kind == KIND_WRITE) begin
						state_d = req_bad ? S_DONE : S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (hit || last) state_d = S_DONE;
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy       = (state_q != S_IDLE);
		done       = (state_q == S_DONE);
		accept     = start && (state_q == S_IDLE);
		hist_clear = accept && (kind == KIND_CLEAR);
		hist_set   = (state_q == S_SCAN) && !hit && last;
	end

	assign status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			status_q <= STATUS_INVALID;
		end else if (accept) begin
			idx_q <= '0;
			case (kind)
				KIND_CLEAR: status_q <= STATUS_CLEARED;
				KIND_READ,
				KIND_WRITE: status_q <= STATUS_INVALID;
				default:    status_q <= STATUS_INVALID;
			endcase
		end else if (state_q == S_SCAN) begin
			idx_q <= idx_q + OBJ_W'(1);
			if (hit) begin
				status_q <= STATUS_REFUSED;
			end else if (last) begin
				status_q <= STATUS_GRANTED;
			end
		end
	end

	// payload of the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			subj_q <= subject;
			obj_q  <= object;
			firm_q <= firm_req;
			row_q  <= hist_q[subject];
		end
	end

	// history rows: clear all, or record a grant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SUBJECT_COUNT; s++) hist_q[s] <= '0;
		end else if (hist_clear) begin
			for (int s = 0; s < SUBJECT_COUNT; s++) hist_q[s] <= '0;
		end else if (hist_set) begin
			hist_q[subj_q] <= row_q | (OBJECT_COUNT'(1) << obj_q);
		end
	end

	// checks
	`CWAC_ASSERT_NXT(a_done_pulse, done, !done, "done held longer than one cycle")
	`CWAC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`CWAC_ASSERT_IMP(a_scan_range, state_q == S_SCAN, NOBJ_W'(idx_q) < n_obj,
		"scan index ran past objects in use")
	`CWAC_ASSERT_IMP(a_grant_recorded, done && status_q == STATUS_GRANTED,
		hist_q[subj_q][obj_q], "grant not recorded in history")
	`CWAC_ASSERT_IMP(a_refuse_from_scan, done && status_q == STATUS_REFUSED,
		$past(state_q) == S_SCAN, "refusal without a scan")

endmodule

// ===== dv/chinese_wall_access_check_core_tb.sv =====
// ----------------------------------------------------------------------------
// chinese_wall_access_check_core_tb
// drives clear/read/write words through the checker under changing owner
// tables, conflict matrices and sizes in use; a local history model predicts
// each status and a monitor compares every done pulse in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chinese_wall_access_check_core_tb;
	import cwac_pkg::*;

	// the one request code the package leaves unnamed
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [2:0]  subject;
	logic [3:0]  object;
	logic        done;
	logic [1:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// local copy of the checker state and registers
	logic [15:0] history_rows [SUBJECT_COUNT];
	logic [47:0] owner_reg;
	logic [63:0] conflict_reg;
	logic [3:0]  subjects_reg;
	logic [4:0]  objects_reg;

	status_t     status_q [$];
	int          err_count;
	bit          idle_on;

	chinese_wall_access_check_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.kind    (kind),
		.subject (subject),
		.object  (object),
		.done    (done),
		.status  (status),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// history model: returns the status of one word and updates the rows
	function automatic status_t predict_status(logic [1:0] k, logic [2:0] s, logic [3:0] o);
		int unsigned n_subj;
		int unsigned n_obj;
		logic [2:0]  f;
		logic [2:0]  g;
		logic [15:0] row;
		if (k == KIND_CLEAR) begin
			for (int i = 0; i < SUBJECT_COUNT; i++) history_rows[i] = '0;
			return STATUS_CLEARED;
		end
		if (k == KIND_UNKNOWN) return STATUS_INVALID;
		n_subj = (subjects_reg > SUBJECT_COUNT) ? SUBJECT_COUNT : subjects_reg;
		n_obj  = (objects_reg > OBJECT_COUNT) ? OBJECT_COUNT : objects_reg;
		if (s >= n_subj || o >= n_obj) return STATUS_INVALID;
		f   = owner_reg[3*o +: 3];
		row = history_rows[s];
		// entries at or beyond the objects in use are stale and skipped
		for (int i = 0; i < n_obj; i++) begin
			if (row[i]) begin
				g = owner_reg[3*i +: 3];
				if (g != f && conflict_reg[{f, g}]) return STATUS_REFUSED;
			end
		end
		history_rows[s] = row | (16'h1 << o);
		return STATUS_GRANTED;
	endfunction

	function automatic logic [63:0] model_reg(reg_idx_t idx);
		case (idx)
			REG_OWNER:    return {16'h0, owner_reg};
			REG_CONFLICT: return conflict_reg;
			REG_SUBJECTS: return {60'h0, subjects_reg};
			default:      return {59'h0, objects_reg};
		endcase
	endfunction

	// result monitor: every done pulse takes the oldest expected status
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (status_q.size() == 0) begin
				$error("status: no word outstanding, actual %0d", status);
				err_count++;
			end else begin
				status_t exp_status;
				exp_status = status_q.pop_front();
				if (status !== exp_status) begin
					$error("status: expected %0d, actual %0d", exp_status, status);
					err_count++;
				end
			end
		end
	end

	// send one request word, with an optional idle burst ahead of it
	task automatic send_word(logic [1:0] k, logic [2:0] s, logic [3:0] o);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start   <= 1'b1;
		kind    <= k;
		subject <= s;
		object  <= o;
		do @(posedge clk); while (!(start && !busy));
		status_q.push_back(predict_status(k, s, o));
	endtask

	// drop start and wait until every word has come back
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (status_q.size() != 0 || busy);
	endtask

	task automatic check_reg(reg_idx_t idx);
		logic [63:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 3'b000};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== model_reg(idx)) begin
			$error("%s: expected %h, actual %h", idx.name(), model_reg(idx), rd);
			err_count++;
		end
	endtask

	// register write while idle, then read it back
	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		wait_idle();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_OWNER:    owner_reg    = val[47:0];
			REG_CONFLICT: conflict_reg = val;
			REG_SUBJECTS: subjects_reg = val[3:0];
			default:      objects_reg  = val[4:0];
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_reg(idx);
	endtask

	task automatic write_sizes(logic [3:0] n_subj, logic [4:0] n_obj);
		write_reg(REG_SUBJECTS, {60'h0, n_subj});
		write_reg(REG_OBJECTS, {59'h0, n_obj});
	endtask

	task automatic test_register_reset();
		check_reg(REG_OWNER);
		check_reg(REG_CONFLICT);
		check_reg(REG_SUBJECTS);
		check_reg(REG_OBJECTS);
	endtask

	// firms 1,2,3,7 in blocks of four objects; 1-2 and 3-7 conflict, 1 with itself
	task automatic test_grant_refuse();
		logic [63:0] cm;
		cm = '0;
		cm[{3'd1, 3'd2}] = 1'b1;
		cm[{3'd2, 3'd1}] = 1'b1;
		cm[{3'd3, 3'd7}] = 1'b1;
		cm[{3'd7, 3'd3}] = 1'b1;
		cm[{3'd1, 3'd1}] = 1'b1;
		write_reg(REG_OWNER, 64'h0000_FFF6_DB49_2249);
		write_reg(REG_CONFLICT, cm);
		send_word(KIND_READ, 3'd0, 4'd0);
		send_word(KIND_WRITE, 3'd0, 4'd1);
		send_word(KIND_READ, 3'd0, 4'd4);
		send_word(KIND_WRITE, 3'd0, 4'd8);
		send_word(KIND_READ, 3'd0, 4'd12);
		send_word(KIND_WRITE, 3'd0, 4'd12);
		send_word(KIND_READ, 3'd7, 4'd15);
		send_word(KIND_WRITE, 3'd7, 4'd0);
		send_word(KIND_CLEAR, 3'd5, 4'd9);
		send_word(KIND_READ, 3'd0, 4'd4);
		send_word(KIND_WRITE, 3'd0, 4'd0);
	endtask

	task automatic test_special_cases();
		// unknown kind
		send_word(KIND_UNKNOWN, 3'd7, 4'd15);
		send_word(KIND_UNKNOWN, 3'd0, 4'd0);
		// sizes above their bounds are capped
		write_sizes(4'd15, 5'd31);
		send_word(KIND_READ, 3'd7, 4'd15);
		send_word(KIND_WRITE, 3'd6, 4'd14);
		// invalid indices and stale history beyond the objects in use
		write_sizes(4'd2, 5'd4);
		send_word(KIND_READ, 3'd2, 4'd0);
		send_word(KIND_WRITE, 3'd0, 4'd4);
		send_word(KIND_READ, 3'd0, 4'd0);
		send_word(KIND_WRITE, 3'd1, 4'd3);
		// zero sizes make every index invalid
		write_sizes(4'd0, 5'd0);
		send_word(KIND_READ, 3'd0, 4'd0);
		send_word(KIND_WRITE, 3'd7, 4'd15);
		send_word(KIND_CLEAR, 3'd0, 4'd0);
		write_sizes(4'd8, 5'd16);
		write_reg(REG_CONFLICT, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_OWNER, 64'h0000_FFFF_FFFF_FFFF);
		send_word(KIND_READ, 3'd3, 4'd5);
		send_word(KIND_WRITE, 3'd3, 4'd6);
	endtask

	// one phase: new settings, then mostly well-formed reads and writes
	task automatic random_phase(int n_items, int setting);
		int unsigned n_subj;
		int unsigned n_obj;
		int unsigned nfirm;
		int unsigned density;
		int          r;
		logic [63:0] own;
		logic [63:0] cm;
		logic [1:0]  k;
		own = '0;
		cm  = '0;
		case (setting)
			0: begin
				own = 64'h0000_FFFF_FFFF_FFFF;
				cm  = 64'hFFFF_FFFF_FFFF_FFFF;
				write_sizes(4'd15, 5'd31);
			end
			1: begin
				write_sizes(4'd1, 5'd1);
			end
			default: begin
				nfirm   = $urandom_range(2, 8);
				density = $urandom_range(10, 90);
				for (int i = 0; i < OBJECT_COUNT; i++)
					own[3*i +: 3] = 3'($urandom_range(0, nfirm - 1));
				if ($urandom_range(0, 5) == 0) own = {$urandom, $urandom};
				for (int a = 0; a < FIRM_COUNT; a++)
					for (int b = a; b < FIRM_COUNT; b++)
						if ($urandom_range(0, 99) < density) begin
							cm[a*8 + b] = 1'b1;
							cm[b*8 + a] = 1'b1;
						end
				if ($urandom_range(0, 5) == 0) cm = {$urandom, $urandom};
				if ($urandom_range(0, 2) == 0)
					write_sizes(4'd8, 5'd16);
				else
					write_sizes(4'($urandom_range(1, 15)), 5'($urandom_range(1, 31)));
			end
		endcase
		write_reg(REG_OWNER, own);
		write_reg(REG_CONFLICT, cm);
		n_subj = (subjects_reg > SUBJECT_COUNT) ? SUBJECT_COUNT : subjects_reg;
		n_obj  = (objects_reg > OBJECT_COUNT) ? OBJECT_COUNT : objects_reg;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			k = ($urandom_range(0, 1) == 0) ? KIND_READ : KIND_WRITE;
			if (r < 3)
				send_word(KIND_CLEAR, 3'($urandom), 4'($urandom));
			else if (r < 6)
				send_word(KIND_UNKNOWN, 3'($urandom), 4'($urandom));
			else if (r < 12)
				send_word(2'($urandom), 3'($urandom), 4'($urandom));
			else
				send_word(k, 3'($urandom_range(0, n_subj - 1)),
					4'($urandom_range(0, n_obj - 1)));
		end
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 10; p++) random_phase(100, p);
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		random_phase(120, 2);
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		start     = 1'b0;
		kind      = KIND_CLEAR;
		subject   = '0;
		object    = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		err_count = 0;
		idle_on   = 1'b1;
		owner_reg    = '0;
		conflict_reg = '0;
		subjects_reg = 4'd8;
		objects_reg  = 5'd16;
		for (int i = 0; i < SUBJECT_COUNT; i++) history_rows[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_reset();
		test_grant_refuse();
		test_special_cases();
		test_random_traffic();
		test_no_idle();

		wait_idle();
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
